// ===== hdl/esrm_pkg.sv =====
// Shared widths, constants, register map and result type for the encoder stuck monitor.
package esrm_pkg;

    localparam int RAW_W          = 16;
    localparam int ANGLE_W        = 14;
    localparam int IDX_W          = 3;
    localparam int MASK_W         = 8;
    localparam int THR_W          = 8;
    localparam int NUM_ENC_DEF    = 3;
    localparam int NUM_ENC_MAX    = 8;

    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd100;

    // Register index, taken from the word address bit of paddr
    localparam logic REG_STUCK_THRESHOLD = 1'b0;

    typedef struct packed {
        logic [IDX_W-1:0]   encoder_index;
        logic [ANGLE_W-1:0] angle;
        logic               frame_done;
        logic               all_stuck;
        logic [MASK_W-1:0]  stuck_mask;
    } result_t;

endpackage

// ===== hdl/esrm_cfg.sv =====
// APB register block holding the stuck threshold.
module esrm_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [esrm_pkg::PADDR_W-1:0]     paddr,
    input  logic [esrm_pkg::PDATA_W-1:0]     pwdata,
    output logic [esrm_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    output logic [esrm_pkg::THR_W-1:0]       threshold
);

    logic [esrm_pkg::THR_W-1:0] thr_reg;
    logic [esrm_pkg::THR_W-1:0] thr_next;
    logic                       sel_thr;

    assign sel_thr = (paddr[2] == esrm_pkg::REG_STUCK_THRESHOLD);
    assign pready  = 1'b1;

    always_comb
    begin
        thr_next = thr_reg;
        if (psel && penable && pwrite && pready && sel_thr)
        begin
            thr_next = pwdata[esrm_pkg::THR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= esrm_pkg::THRESHOLD_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    assign prdata    = sel_thr ? esrm_pkg::PDATA_W'(thr_reg) : '0;
    assign threshold = thr_reg;

endmodule

// ===== hdl/esrm_core.sv =====
// Per-slot repeat tracking, frame-level stuck detection and the result register.
module esrm_core #(
    parameter int NUM_ENCODERS = esrm_pkg::NUM_ENC_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [esrm_pkg::THR_W-1:0]     threshold,
    input  logic                           item_valid,
    input  logic [esrm_pkg::ANGLE_W-1:0]   item_angle,
    output logic                           advance,
    output logic                           result_valid,
    input  logic                           result_stall,
    output esrm_pkg::result_t              result
);

    localparam int SLOT_W = (NUM_ENCODERS > 1) ? $clog2(NUM_ENCODERS) : 1;
    localparam logic [SLOT_W-1:0] LAST_POS = SLOT_W'(NUM_ENCODERS - 1);
    localparam logic [esrm_pkg::MASK_W-1:0] ENC_BITS =
        esrm_pkg::MASK_W'((1 << NUM_ENCODERS) - 1);

    logic [SLOT_W-1:0]            pos_reg;
    logic [SLOT_W-1:0]            pos_next;
    logic [esrm_pkg::ANGLE_W-1:0] prev_angle_reg [NUM_ENCODERS];
    logic [esrm_pkg::THR_W-1:0]   cnt_reg        [NUM_ENCODERS];
    logic                         fas_reg;
    logic                         fas_next;
    logic [esrm_pkg::THR_W-1:0]   fcnt_reg;
    logic [esrm_pkg::THR_W-1:0]   fcnt_next;
    logic [NUM_ENCODERS-1:0]      flags_reg;
    logic [NUM_ENCODERS-1:0]      flags_next;
    logic                         all_reg;
    logic                         all_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    esrm_pkg::result_t            res_reg;
    esrm_pkg::result_t            res_next;

    logic                         fire;
    logic [SLOT_W-1:0]            slot;
    logic                         match;
    logic                         done;
    logic                         fas_eff;
    logic [esrm_pkg::THR_W-1:0]   cnt_upd;
    logic [esrm_pkg::THR_W-1:0]   cnt_new [NUM_ENCODERS];
    logic [esrm_pkg::THR_W-1:0]   fcnt_upd;
    logic [NUM_ENCODERS-1:0]      flags_upd;
    logic                         all_upd;

    assign advance = !out_valid_reg || !result_stall;
    assign fire    = item_valid && advance;
    assign slot    = LAST_POS - pos_reg;
    assign done    = (pos_reg == LAST_POS);
    assign match   = (item_angle == prev_angle_reg[slot]);
    // A new frame starts with every slot assumed repeated
    assign fas_eff = (pos_reg == '0) ? 1'b1 : fas_reg;

    always_comb
    begin
        if (!match)
        begin
            cnt_upd = '0;
        end
        else if (cnt_reg[slot] < threshold)
        begin
            cnt_upd = cnt_reg[slot] + 1'b1;
        end
        else
        begin
            cnt_upd = cnt_reg[slot];
        end

        for (int i = 0; i < NUM_ENCODERS; i++)
        begin
            cnt_new[i]   = (SLOT_W'(i) == slot) ? cnt_upd : cnt_reg[i];
            flags_upd[i] = (cnt_new[i] >= threshold);
        end

        fas_next = fas_eff && match;

        if (!fas_next)
        begin
            fcnt_upd = '0;
        end
        else if (fcnt_reg < threshold)
        begin
            fcnt_upd = fcnt_reg + 1'b1;
        end
        else
        begin
            fcnt_upd = fcnt_reg;
        end
        all_upd = (fcnt_upd >= threshold);

        pos_next   = done ? '0 : pos_reg + 1'b1;
        fcnt_next  = done ? fcnt_upd  : fcnt_reg;
        flags_next = done ? flags_upd : flags_reg;
        all_next   = done ? all_upd   : all_reg;

        res_next.encoder_index = esrm_pkg::IDX_W'(slot);
        res_next.angle         = item_angle;
        res_next.frame_done    = done;
        res_next.all_stuck     = all_next;
        res_next.stuck_mask    = esrm_pkg::MASK_W'(flags_next);

        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (advance)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            fas_reg       <= 1'b1;
            fcnt_reg      <= '0;
            flags_reg     <= '0;
            all_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_ENCODERS; i++)
            begin
                prev_angle_reg[i] <= '0;
                cnt_reg[i]        <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire)
            begin
                pos_reg              <= pos_next;
                fas_reg              <= fas_next;
                fcnt_reg             <= fcnt_next;
                flags_reg            <= flags_next;
                all_reg              <= all_next;
                prev_angle_reg[slot] <= item_angle;
                cnt_reg[slot]        <= cnt_upd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = res_reg;

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("frame position out of range");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        fire && done |=> pos_reg == '0)
        else $error("frame position did not wrap after last word");

    a_first_slot: assert property (@(posedge clk) disable iff (!rst_n)
        fire && pos_reg == '0 |=> res_reg.encoder_index == esrm_pkg::IDX_W'(LAST_POS))
        else $error("first word of frame not sent to highest slot");

    a_mask_bits: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (res_reg.stuck_mask & ~ENC_BITS) == '0)
        else $error("stuck mask bit set above encoder count");

    a_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_reg.frame_done == (res_reg.encoder_index == '0))
        else $error("frame done flag disagrees with slot");
`endif

endmodule

// ===== hdl/encoder_stuck_reading_monitor.sv =====
// Top level of the encoder stuck-reading monitor: word input register, core, register port.
//
// Accepts one 16-bit chain word per clock while word_stall is low and returns one result
// per word, in order. A word passes through the input register and then the result
// register before its result is offered; with no result stall one word enters and one
// result leaves every cycle. word_stall rises only while the input register is full and
// the waiting result is stalled. A frame is NUM_ENCODERS words (1 to 8); its first word
// lands in the highest slot. Repeat counts and the all-repeat frame count saturate at
// stuck_threshold (register 0, byte address 0, reset 100); stuck_mask and all_stuck
// change only on the word that ends a frame. Write the threshold only while no transfer
// is in flight.
module encoder_stuck_reading_monitor #(
    parameter int NUM_ENCODERS = esrm_pkg::NUM_ENC_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [esrm_pkg::PADDR_W-1:0]     paddr,
    input  logic [esrm_pkg::PDATA_W-1:0]     pwdata,
    output logic [esrm_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    input  logic                             word_valid,
    output logic                             word_stall,
    input  logic [esrm_pkg::RAW_W-1:0]       raw_word,
    output logic                             result_valid,
    input  logic                             result_stall,
    output logic [esrm_pkg::IDX_W-1:0]       encoder_index,
    output logic [esrm_pkg::ANGLE_W-1:0]     angle,
    output logic                             frame_done,
    output logic                             all_stuck,
    output logic [esrm_pkg::MASK_W-1:0]      stuck_mask
);

    logic [esrm_pkg::THR_W-1:0]   threshold;
    logic                         s1_valid_reg;
    logic                         s1_valid_next;
    logic [esrm_pkg::ANGLE_W-1:0] s1_angle_reg;
    logic                         advance;
    logic                         word_xfer;
    esrm_pkg::result_t            result;

    esrm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .threshold (threshold)
    );

    // Input stage holds while the core cannot take it
    assign word_stall    = s1_valid_reg && !advance;
    assign word_xfer     = word_valid && !word_stall;
    assign s1_valid_next = word_xfer || (s1_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_xfer)
        begin
            s1_angle_reg <= raw_word[esrm_pkg::ANGLE_W-1:0];
        end
    end

    esrm_core #(
        .NUM_ENCODERS (NUM_ENCODERS)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .threshold    (threshold),
        .item_valid   (s1_valid_reg),
        .item_angle   (s1_angle_reg),
        .advance      (advance),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign encoder_index = result.encoder_index;
    assign angle         = result.angle;
    assign frame_done    = result.frame_done;
    assign all_stuck     = result.all_stuck;
    assign stuck_mask    = result.stuck_mask;

endmodule

// ===== tb/sv/encoder_stuck_reading_monitor_tb.sv =====
// Self-checking testbench for the encoder stuck-reading monitor: driver, checker, registers.
module encoder_stuck_reading_monitor_tb;

    import esrm_pkg::*;

    localparam int NENC = NUM_ENC_DEF;
    localparam logic [PADDR_W-1:0] THR_ADDR = PADDR_W'(4 * int'(REG_STUCK_THRESHOLD));

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                word_valid = 1'b0;
    logic                word_stall;
    logic [RAW_W-1:0]    raw_word = '0;
    logic                result_valid;
    logic                result_stall = 1'b0;
    logic [IDX_W-1:0]    encoder_index;
    logic [ANGLE_W-1:0]  angle;
    logic                frame_done;
    logic                all_stuck;
    logic [MASK_W-1:0]   stuck_mask;

    encoder_stuck_reading_monitor i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .word_valid    (word_valid),
        .word_stall    (word_stall),
        .raw_word      (raw_word),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .encoder_index (encoder_index),
        .angle         (angle),
        .frame_done    (frame_done),
        .all_stuck     (all_stuck),
        .stuck_mask    (stuck_mask)
    );

    always #4 clk = ~clk;

    // Predicted monitor state
    logic [THR_W-1:0]   thr_cfg = THRESHOLD_RESET;
    int unsigned        wpos = 0;
    logic [ANGLE_W-1:0] prev_ang [NENC];
    logic [7:0]         rep_cnt [NENC];
    logic               all_same = 1'b1;
    logic [7:0]         same_frames = '0;
    logic [MASK_W-1:0]  mask_flags = '0;
    logic               all_flag = 1'b0;

    result_t            pending_readings [$];
    logic [RAW_W-1:0]   word_queue [$];

    // Stimulus generator view of the chain
    logic [ANGLE_W-1:0] gen_last [NENC];
    int unsigned        gen_pos = 0;

    int unsigned        queued_words = 0;
    int unsigned        accepted_words = 0;
    int unsigned        results_seen = 0;
    int unsigned        frames_seen = 0;
    int unsigned        all_stuck_seen = 0;
    int unsigned        mask_seen = 0;
    int unsigned        settings_used = 1;
    int unsigned        mismatches = 0;

    logic               quiet = 1'b0;
    logic               hold_go = 1'b0;
    logic               hold_used = 1'b0;
    int unsigned        hold_left = 0;

    initial
    begin
        for (int i = 0; i < NENC; i++)
        begin
            prev_ang[i] = '0;
            rep_cnt[i] = '0;
            gen_last[i] = '0;
        end
    end

    task automatic track_reading(input logic [RAW_W-1:0] w);
        logic [ANGLE_W-1:0] a;
        int unsigned        p;
        int unsigned        s;
        result_t            r;
        a = w[ANGLE_W-1:0];
        p = (wpos >= NENC) ? 0 : wpos;
        if (p == 0)
            all_same = 1'b1;
        s = NENC - 1 - p;
        if (a == prev_ang[s])
        begin
            if (rep_cnt[s] < thr_cfg)
                rep_cnt[s] = rep_cnt[s] + 8'd1;
        end
        else
        begin
            rep_cnt[s] = '0;
            all_same = 1'b0;
        end
        prev_ang[s] = a;
        p++;
        r.frame_done = (p >= NENC);
        if (r.frame_done)
        begin
            if (all_same)
            begin
                if (same_frames < thr_cfg)
                    same_frames = same_frames + 8'd1;
            end
            else
                same_frames = '0;
            all_flag = (same_frames >= thr_cfg);
            mask_flags = '0;
            for (int i = 0; i < NENC; i++)
                if (rep_cnt[i] >= thr_cfg)
                    mask_flags[i] = 1'b1;
            p = 0;
        end
        wpos = p;
        r.encoder_index = IDX_W'(s);
        r.angle = a;
        r.all_stuck = all_flag;
        r.stuck_mask = mask_flags;
        pending_readings.push_back(r);
    endtask

    // Word driver: offers the next queued word, idles at random between transfers
    always @(posedge clk or negedge rst_n)
    begin : word_drv
        logic nxt_valid;
        logic [RAW_W-1:0] nxt_word;
        if (!rst_n)
        begin
            word_valid <= 1'b0;
            raw_word <= '0;
        end
        else
        begin
            if (word_valid && !word_stall)
            begin
                track_reading(raw_word);
                accepted_words++;
            end
            if (!(word_valid && word_stall))
            begin
                nxt_valid = 1'b0;
                nxt_word = raw_word;
                if (word_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= 9))
                begin
                    nxt_valid = 1'b1;
                    nxt_word = word_queue.pop_front();
                end
                word_valid <= nxt_valid;
                raw_word <= nxt_word;
            end
        end
    end

    // Long receiver hold-off, fired once
    always @(posedge clk)
    begin
        if (hold_go && !hold_used)
        begin
            hold_left <= 80;
            hold_used <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Result checker
    always @(posedge clk or negedge rst_n)
    begin : result_mon
        result_t got;
        result_t want;
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                got.encoder_index = encoder_index;
                got.angle = angle;
                got.frame_done = frame_done;
                got.all_stuck = all_stuck;
                got.stuck_mask = stuck_mask;
                results_seen++;
                if (frame_done)
                    frames_seen++;
                if (frame_done && all_stuck)
                    all_stuck_seen++;
                if (frame_done && stuck_mask != '0)
                    mask_seen++;
                if (pending_readings.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: slot %0d angle %h done %b all %b mask %b",
                                 got.encoder_index, got.angle, got.frame_done,
                                 got.all_stuck, got.stuck_mask);
                end
                else
                begin
                    want = pending_readings.pop_front();
                    if (got.encoder_index !== want.encoder_index || got.angle !== want.angle
                        || got.frame_done !== want.frame_done
                        || got.all_stuck !== want.all_stuck
                        || got.stuck_mask !== want.stuck_mask)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch at result %0d (exp/got): slot %0d/%0d ",
                                      "angle %h/%h done %b/%b all %b/%b mask %b/%b"},
                                     results_seen, want.encoder_index, got.encoder_index,
                                     want.angle, got.angle, want.frame_done, got.frame_done,
                                     want.all_stuck, got.all_stuck,
                                     want.stuck_mask, got.stuck_mask);
                    end
                end
            end
            result_stall <= (hold_left != 0) || (!quiet && $urandom_range(0, 99) < 9);
        end
    end

    task automatic push_word(input logic [RAW_W-1:0] w);
        gen_last[NENC - 1 - gen_pos] = w[ANGLE_W-1:0];
        gen_pos = (gen_pos + 1 == NENC) ? 0 : gen_pos + 1;
        word_queue.push_back(w);
        queued_words++;
    endtask

    // Mostly frames that repeat earlier readings, some with one or every slot moving, some noise
    task automatic gen_frames(input int n_frames);
        int unsigned        mode;
        int unsigned        moving;
        int unsigned        s;
        logic [1:0]         junk;
        logic [ANGLE_W-1:0] a;
        repeat (n_frames)
        begin
            mode = $urandom_range(0, 99);
            moving = $urandom_range(0, NENC - 1);
            for (int k = 0; k < NENC; k++)
            begin
                s = NENC - 1 - gen_pos;
                junk = 2'($urandom_range(0, 3));
                a = gen_last[s];
                if (mode < 65 || (mode < 85 && s != moving))
                    push_word({junk, a});
                else if (mode < 92)
                    push_word({junk, a ^ (ANGLE_W'(1) << $urandom_range(0, ANGLE_W - 1))});
                else
                    push_word(RAW_W'($urandom_range(0, 65535)));
            end
        end
    endtask

    task automatic wait_drained();
        while (accepted_words != queued_words || pending_readings.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [THR_W-1:0] v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= THR_ADDR;
        pwdata <= PDATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        thr_cfg = v;
    endtask

    task automatic apb_check();
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= THR_ADDR;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== PDATA_W'(thr_cfg))
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("threshold readback: expected %0d got %0d", thr_cfg, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic new_setting(input logic [THR_W-1:0] v);
        wait_drained();
        apb_write(v);
        apb_check();
        settings_used++;
        @(negedge clk);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        apb_check();
        @(negedge clk);
        // angle 0 right after reset counts as a repeat; high bits are dropped
        push_word(16'h0000); push_word(16'hC000); push_word(16'h4000);
        push_word(16'hFFFF); push_word(16'h3FFF); push_word(16'h8000);
        new_setting(8'd1);
        push_word(16'hFFFF); push_word(16'h7FFF); push_word(16'h0000);
        push_word(16'hFFFF); push_word(16'h3FFF); push_word(16'h1234);
        push_word(16'h2AAA); push_word(16'h1555); push_word(16'h1234);
        new_setting(8'd3);
        repeat (3)
        begin
            push_word(16'h2AAA); push_word(16'h9555); push_word(16'h5234);
        end
        // counts sitting at 3 stay there after the threshold drops
        new_setting(8'd1);
        gen_frames(25);
        new_setting(8'd6);
        quiet <= 1'b1;
        gen_frames(30);
        wait_drained();
        quiet <= 1'b0;
        new_setting(8'd2);
        gen_frames(25);
        new_setting(8'd255);
        hold_go <= 1'b1;
        gen_frames(25);
        new_setting(8'd3);
        gen_frames(25);
        repeat (2)
        begin
            new_setting(THR_W'($urandom_range(1, 12)));
            gen_frames(25);
        end
        wait_drained();
        repeat (6) @(posedge clk);
        $display("Ran %0d words (%0d frames) through %0d threshold settings from 1 to 255;",
                 accepted_words, frames_seen, settings_used);
        $display("%0d frame ends had all encoders stuck, %0d had some stuck flag set.",
                 all_stuck_seen, mask_seen);
        if (mismatches == 0 && pending_readings.size() == 0)
            $display("CHECK OK");
        else
        begin
            $display("%0d mismatches, %0d results never arrived", mismatches,
                     pending_readings.size());
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial
    begin
        #400000;
        $display("timeout: %0d of %0d words accepted, %0d results outstanding",
                 accepted_words, queued_words, pending_readings.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule
